[src/latm2adts_pkg.sv]
`default_nettype none

package latm2adts_pkg;

   // status codes on the final result of a frame
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_SYNC   = 3'd1;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
   localparam logic [2:0] ST_BAD_MUX    = 3'd3;
   localparam logic [2:0] ST_BAD_AUDIO  = 3'd4;

   // kinds of queue entries
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_BYTE   = 2'd2;

   // frame parsing constants
   localparam logic [10:0] SYNC_WORD       = 11'h2B7;
   localparam logic [4:0]  AOT_UNSUPPORTED = 5'd28;
   localparam logic [13:0] POS_MAX         = 14'h3FFF;
   localparam logic [3:0]  RATE_INVALID    = 4'hF;
   localparam logic [7:0]  LEN_CONTINUE    = 8'd255;

   // adts header: seven bytes, index of the last one
   localparam logic [2:0] HDR_LAST_IDX = 3'd6;

   // queue between parser and emitter
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = 3;

   // header fields carried in one queue entry
   typedef struct packed {
      logic [1:0]  obj_type;
      logic [3:0]  rate_index;
      logic [2:0]  channels;
      logic [12:0] frame_len;
   } hdr_info_type;

   typedef struct packed {
      logic [1:0]   kind;
      hdr_info_type info;   // for a payload byte, info[7:0] holds it
      logic         last;
      logic [2:0]   status;
   } entry_type;

   // one byte of the adts header
   function automatic logic [7:0] header_byte(input hdr_info_type h, input logic [2:0] idx);
      logic [7:0] res;
      res = 8'h00;
      unique case (idx)
         3'd0: res = 8'hFF;
         3'd1: res = 8'hF1;
         3'd2: res = {h.obj_type, h.rate_index, 1'b1, h.channels[2]};
         3'd3: res = {h.channels[1:0], 4'hF, h.frame_len[12:11]};
         3'd4: res = h.frame_len[10:3];
         3'd5: res = {h.frame_len[2:0], 5'h1F};
         3'd6: res = 8'hFC;
         default: res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

[src/latm_to_adts_frame_converter.sv]
// LOAS/LATM to ADTS frame converter.
// Input channel (req_): one frame byte per transfer, req_frame_end on the
// frame's last byte. Output channel (rsp_): the 7-byte ADTS header followed
// by the realigned payload bytes; rsp_last marks the frame's final result
// and rsp_status carries its status there (0 elsewhere). When the last byte
// of a frame produces no frame byte, one status-only result with
// rsp_byte_valid low is sent.
// The entries for an accepted byte are written into the queue, then loaded
// into the output register that drives rsp_.
// Throughput: one input byte per cycle sustained unless the receiver stalls.
// The header leaves as a burst of 7 bytes; an 8-entry queue between parser
// and emitter absorbs it, and req_ready drops only while that queue is full.
// When the receiver stalls, the current result holds on rsp_ and the queue
// fills, after which req_ready goes low until space frees up.
// Synchronous reset clears the parser state, the queue and the output
// register; the block accepts bytes as soon as reset is released.
`default_nettype none

module latm_to_adts_frame_converter (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [7:0]  req_data_byte,
   input  wire        req_frame_end,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic [2:0] rsp_status
);

   logic                     accept;
   logic                     push;
   latm2adts_pkg::entry_type push_entry;
   logic                     q_full;
   logic                     q_not_empty;
   latm2adts_pkg::entry_type q_head;
   logic                     q_pop;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // parser
   latm2adts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .frame_end  (req_frame_end),
      .push       (push),
      .push_entry (push_entry)
   );

   // entry queue
   latm2adts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // byte emitter
   latm2adts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_byte    (rsp_out_byte),
      .byte_valid  (rsp_byte_valid),
      .last        (rsp_last),
      .status      (rsp_status)
   );

endmodule

`default_nettype wire

[src/latm2adts_front.sv]
`default_nettype none

module latm2adts_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      accept,
   input  wire [7:0]                data_byte,
   input  wire                      frame_end,
   output logic                     push,
   output latm2adts_pkg::entry_type push_entry
);

   logic [13:0] pos_ff, pos_in;
   logic [7:0]  prev_ff, prev_in;
   logic [13:0] mux_ff, mux_in;
   logic [13:0] slot_ff, slot_in;
   logic        lid_ff, lid_in;
   logic [13:0] left_ff, left_in;
   logic [1:0]  obj_ff, obj_in;
   logic [3:0]  rate_ff, rate_in;
   logic [2:0]  chan_ff, chan_in;
   logic [2:0]  err_ff, err_in;

   logic [4:0]  aot;
   logic [7:0]  realigned;
   logic [14:0] slot_sum;
   logic [14:0] count;
   logic [14:0] mux_plus;
   logic [3:0]  rate_new;

   assign aot       = data_byte[7:3];
   assign realigned = {prev_ff[2:0], data_byte[7:3]};
   assign slot_sum  = {1'b0, slot_ff} + {7'd0, realigned};
   assign count     = {1'b0, pos_ff} + 15'd1;
   assign rate_new  = {prev_ff[2:0], data_byte[7]};

   // parse one byte, build the queue entry
   always_comb begin
      pos_in     = pos_ff;
      prev_in    = prev_ff;
      mux_in     = mux_ff;
      slot_in    = slot_ff;
      lid_in     = lid_ff;
      left_in    = left_ff;
      obj_in     = obj_ff;
      rate_in    = rate_ff;
      chan_in    = chan_ff;
      err_in     = err_ff;
      push       = 1'b0;
      push_entry = '0;
      mux_plus   = '0;
      if (accept) begin
         priority if (pos_ff == 14'd1) begin
            if ({prev_ff, data_byte[7:5]} != latm2adts_pkg::SYNC_WORD)
               err_in = latm2adts_pkg::ST_BAD_SYNC;
         end else if (pos_ff == 14'd2) begin
            mux_in = {1'b0, prev_ff[4:0], data_byte};
         end else if (pos_ff == 14'd3) begin
            if (err_ff == latm2adts_pkg::ST_OK && (data_byte[7] || data_byte[4:0] != 5'd0))
               err_in = latm2adts_pkg::ST_BAD_MUX;
         end else if (pos_ff == 14'd4) begin
            if (err_ff == latm2adts_pkg::ST_OK && data_byte != 8'd0)
               err_in = latm2adts_pkg::ST_BAD_MUX;
         end else if (pos_ff == 14'd5) begin
            obj_in = (aot >= 5'd1 && aot <= 5'd3) ? (aot[1:0] - 2'd1) : 2'd3;
            if (err_ff == latm2adts_pkg::ST_OK && aot == latm2adts_pkg::AOT_UNSUPPORTED)
               err_in = latm2adts_pkg::ST_BAD_AUDIO;
         end else if (pos_ff == 14'd6) begin
            rate_in = rate_new;
            chan_in = data_byte[5:3];
            if (err_ff == latm2adts_pkg::ST_OK &&
                (rate_new == latm2adts_pkg::RATE_INVALID || data_byte[2:0] != 3'd0))
               err_in = latm2adts_pkg::ST_BAD_AUDIO;
         end else if (pos_ff == 14'd7) begin
            if (err_ff == latm2adts_pkg::ST_OK && data_byte[7:5] != 3'd0)
               err_in = latm2adts_pkg::ST_BAD_MUX;
         end else if (pos_ff == 14'd8) begin
            if (err_ff == latm2adts_pkg::ST_OK && (data_byte[4] || !data_byte[3]))
               err_in = latm2adts_pkg::ST_BAD_MUX;
         end else if (pos_ff >= 14'd10 && err_ff == latm2adts_pkg::ST_OK) begin
            if (!lid_ff) begin
               // payload length info, saturating sum
               slot_in = slot_sum[14] ? latm2adts_pkg::POS_MAX : slot_sum[13:0];
               if (realigned != latm2adts_pkg::LEN_CONTINUE) begin
                  lid_in                       = 1'b1;
                  left_in                      = slot_in;
                  push                         = 1'b1;
                  push_entry.kind              = latm2adts_pkg::KIND_HEADER;
                  push_entry.info.obj_type     = obj_ff;
                  push_entry.info.rate_index   = rate_ff;
                  push_entry.info.channels     = chan_ff;
                  push_entry.info.frame_len    = slot_in[12:0] + 13'd7;
               end
            end else if (left_ff != 14'd0) begin
               push                 = 1'b1;
               push_entry.kind      = latm2adts_pkg::KIND_BYTE;
               push_entry.info[7:0] = realigned;
               left_in              = left_ff - 14'd1;
            end
         end else begin
         end

         prev_in = data_byte;
         if (pos_ff != latm2adts_pkg::POS_MAX)
            pos_in = pos_ff + 14'd1;

         // frame end: final status, then clear for the next frame
         if (frame_end) begin
            mux_plus        = {1'b0, mux_in} + 15'd3;
            push            = 1'b1;
            push_entry.last = 1'b1;
            priority if (pos_ff < 14'd2)
               push_entry.status = latm2adts_pkg::ST_BAD_LENGTH;
            else if (err_in == latm2adts_pkg::ST_BAD_SYNC)
               push_entry.status = latm2adts_pkg::ST_BAD_SYNC;
            else if (count != mux_plus)
               push_entry.status = latm2adts_pkg::ST_BAD_LENGTH;
            else if (err_in != latm2adts_pkg::ST_OK)
               push_entry.status = err_in;
            else if (!lid_in || left_in != 14'd0)
               push_entry.status = latm2adts_pkg::ST_BAD_LENGTH;
            else
               push_entry.status = latm2adts_pkg::ST_OK;
            pos_in  = '0;
            prev_in = '0;
            mux_in  = '0;
            slot_in = '0;
            lid_in  = 1'b0;
            left_in = '0;
            obj_in  = '0;
            rate_in = '0;
            chan_in = '0;
            err_in  = '0;
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         prev_ff <= '0;
         mux_ff  <= '0;
         slot_ff <= '0;
         lid_ff  <= 1'b0;
         left_ff <= '0;
         obj_ff  <= '0;
         rate_ff <= '0;
         chan_ff <= '0;
         err_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
         mux_ff  <= mux_in;
         slot_ff <= slot_in;
         lid_ff  <= lid_in;
         left_ff <= left_in;
         obj_ff  <= obj_in;
         rate_ff <= rate_in;
         chan_ff <= chan_in;
         err_ff  <= err_in;
      end
   end

endmodule

`default_nettype wire

[src/latm2adts_queue.sv]
`default_nettype none

module latm2adts_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  wire latm2adts_pkg::entry_type push_entry,
   input  wire                      pop,
   output logic                     full,
   output logic                     not_empty,
   output latm2adts_pkg::entry_type head
);

   latm2adts_pkg::entry_type slots_ff [latm2adts_pkg::QUEUE_DEPTH];

   logic [latm2adts_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [latm2adts_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [latm2adts_pkg::QUEUE_PTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (latm2adts_pkg::QUEUE_PTR_W+1)'(latm2adts_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push)
         slots_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

[src/latm2adts_back.sv]
`default_nettype none

module latm2adts_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      q_not_empty,
   input  wire latm2adts_pkg::entry_type q_head,
   output logic                     q_pop,
   output logic                     out_valid,
   input  wire                      out_ready,
   output logic [7:0]               out_byte,
   output logic                     byte_valid,
   output logic                     last,
   output logic [2:0]               status
);

   logic                     cur_valid_ff, cur_valid_in;
   latm2adts_pkg::entry_type cur_ff, cur_in;
   logic [2:0]               idx_ff, idx_in;

   logic is_final;
   logic done;
   logic load;

   // final output byte of the current entry
   assign is_final = (cur_ff.kind != latm2adts_pkg::KIND_HEADER) ||
                     (idx_ff == latm2adts_pkg::HDR_LAST_IDX);
   assign done     = cur_valid_ff && out_ready && is_final;
   assign load     = !cur_valid_ff || done;
   assign q_pop    = load && q_not_empty;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_valid_in = q_not_empty;
         cur_in       = q_head;
         idx_in       = '0;
      end else if (out_ready) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // result fields
   always_comb begin
      out_valid  = cur_valid_ff;
      out_byte   = 8'h00;
      byte_valid = 1'b0;
      unique case (cur_ff.kind)
         latm2adts_pkg::KIND_HEADER: begin
            out_byte   = latm2adts_pkg::header_byte(cur_ff.info, idx_ff);
            byte_valid = 1'b1;
         end
         latm2adts_pkg::KIND_BYTE: begin
            out_byte   = cur_ff.info[7:0];
            byte_valid = 1'b1;
         end
         default: begin
            out_byte   = 8'h00;
            byte_valid = 1'b0;
         end
      endcase
      last   = cur_ff.last && is_final;
      status = last ? cur_ff.status : latm2adts_pkg::ST_OK;
   end

endmodule

`default_nettype wire
